[rtl/core/mqttpf_pkg.sv]
// Shared types and constants for the MQTT control packet framer.
`default_nettype none

package mqttpf_pkg;

    typedef enum logic [2:0] {
        KIND_CONNECT     = 3'd0,
        KIND_SUBSCRIBE   = 3'd1,
        KIND_UNSUBSCRIBE = 3'd2,
        KIND_PUBLISH     = 3'd3,
        KIND_PINGREQ     = 3'd4,
        KIND_DISCONNECT  = 3'd5
    } kind_t;

    // position within the payload strings
    typedef enum logic [2:0] {
        PHASE_FIRST         = 3'd0,
        PHASE_SECOND_PREFIX = 3'd1,
        PHASE_SECOND        = 3'd2,
        PHASE_THIRD_PREFIX  = 3'd3,
        PHASE_THIRD         = 3'd4
    } phase_t;

    localparam logic [1:0] REG_KEEP_ALIVE       = 2'd0;
    localparam logic [1:0] REG_CONNECT_FLAGS    = 2'd1;
    localparam logic [1:0] REG_SUBSCRIBE_IDENT  = 2'd2;

    localparam logic [15:0] KEEP_ALIVE_RESET      = 16'd60;
    localparam logic [7:0]  CONNECT_FLAGS_RESET   = 8'hC2;
    localparam logic [15:0] SUBSCRIBE_IDENT_RESET = 16'd1;

    localparam logic [7:0] TYPE_CONNECT     = 8'h10;
    localparam logic [7:0] TYPE_SUBSCRIBE   = 8'h82;
    localparam logic [7:0] TYPE_UNSUBSCRIBE = 8'hA2;
    localparam logic [7:0] TYPE_PUBLISH     = 8'h30;
    localparam logic [7:0] TYPE_PINGREQ     = 8'hC0;
    localparam logic [7:0] TYPE_DISCONNECT  = 8'hE0;

    localparam logic [31:0] PROTOCOL_NAME  = "MQTT";
    localparam logic [7:0]  PROTOCOL_LEVEL = 8'h04;

    localparam int BURST_MAX   = 16;
    localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);
    localparam int BURST_W     = 8 * BURST_MAX;

endpackage

`default_nettype wire

[rtl/core/mqtt_control_packet_framer_top.sv]
// MQTT 3.1.1 control packet framer, top level.
`default_nettype none

// Each accepted word is decoded into a burst of up to 16 packet bytes, held in a 16-byte
// burst register and shifted into the output register one byte per cycle while the
// output is not stalled. A payload word usually yields one byte, so payload streams at
// one word per cycle, likewise unless stalled, via the burst and output registers. A
// header word yields up to 16 bytes. The input stalls until the burst register is down
// to its final byte. Configuration writes are always taken (cfg_ready is tied high).
module mqtt_control_packet_framer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        mode,
    input  logic [2:0]  packet_kind,
    input  logic [15:0] first_length,
    input  logic [15:0] second_length,
    input  logic [15:0] third_length,
    input  logic [1:0]  qos_level,
    input  logic [7:0]  payload_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_packet,
    output logic        status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = mqttpf_pkg::BURST_CNT_W;
    localparam int BW = mqttpf_pkg::BURST_W;

    // configuration
    logic [15:0] keep_alive_reg;
    logic [7:0]  conn_flags_reg;
    logic [15:0] sub_ident_reg;

    // packet state
    mqttpf_pkg::kind_t  open_kind_reg, open_kind_next;
    logic               open_reg, open_next;
    mqttpf_pkg::phase_t phase_reg, phase_next;
    logic [15:0]        len_reg [3];
    logic [15:0]        len_next [3];
    logic [1:0]         held_qos_reg, held_qos_next;
    logic [15:0]        pub_ident_reg, pub_ident_next;

    // burst register
    logic [BW-1:0] buf_data_reg;
    logic [CW-1:0] buf_rem_reg;
    logic          buf_close_reg;
    logic          buf_drop_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_status_reg;

    // burst build
    logic [BW-1:0] burst_vec;
    logic [CW-1:0] burst_cnt;
    logic          burst_close;
    logic          burst_drop;

    logic          accept;
    logic          out_load;

    // header side
    logic [1:0]  qos_sat;
    logic [17:0] rem;
    logic [23:0] vli_vec;
    logic [1:0]  vlen;
    logic [95:0] tail_vec;
    logic [3:0]  tail_cnt;
    logic [7:0]  type_byte;
    logic [5:0]  tail_shift;

    // payload side
    logic [1:0]  seg;
    logic        seg_bad;
    logic [15:0] len_sel;
    logic [15:0] len_dec;
    logic        pre;
    logic        nonzero;
    logic        fire;
    logic [23:0] head_vec;
    logic [1:0]  head_cnt;
    logic [15:0] done_vec;
    logic [1:0]  done_cnt;
    logic        done_close;
    mqttpf_pkg::phase_t done_phase;

    assign qos_sat = (qos_level == 2'd3) ? 2'd2 : qos_level;

    // remaining length and its variable-length encoding
    always_comb
    begin
        unique case (packet_kind)
            mqttpf_pkg::KIND_CONNECT:
            begin
                rem = 18'd12 + {2'b00, first_length}
                    + ((second_length != 16'd0) ? ({2'b00, second_length} + 18'd2) : 18'd0)
                    + ((third_length != 16'd0) ? ({2'b00, third_length} + 18'd2) : 18'd0);
            end
            mqttpf_pkg::KIND_SUBSCRIBE:
            begin
                rem = 18'd5 + {2'b00, first_length};
            end
            mqttpf_pkg::KIND_UNSUBSCRIBE:
            begin
                rem = 18'd4 + {2'b00, first_length};
            end
            mqttpf_pkg::KIND_PUBLISH:
            begin
                rem = 18'd2 + {2'b00, first_length} + {2'b00, second_length}
                    + ((qos_sat != 2'd0) ? 18'd2 : 18'd0);
            end
            default:
            begin
                rem = 18'd0;
            end
        endcase
    end

    always_comb
    begin
        vli_vec = {4'b0000, rem[17:14],
                   (rem[17:14] != 4'd0), rem[13:7],
                   (rem[17:7] != 11'd0), rem[6:0]};
        if (rem[17:14] != 4'd0)
        begin
            vlen = 2'd3;
        end
        else if (rem[17:7] != 11'd0)
        begin
            vlen = 2'd2;
        end
        else
        begin
            vlen = 2'd1;
        end
        tail_shift = {({1'b0, vlen} + 3'd1), 3'b000};
    end

    // type byte and fixed header tail
    always_comb
    begin
        tail_vec  = '0;
        tail_cnt  = 4'd0;
        type_byte = mqttpf_pkg::TYPE_DISCONNECT;
        unique case (packet_kind)
            mqttpf_pkg::KIND_CONNECT:
            begin
                type_byte = mqttpf_pkg::TYPE_CONNECT;
                tail_vec  = {first_length[7:0], first_length[15:8],
                             keep_alive_reg[7:0], keep_alive_reg[15:8],
                             conn_flags_reg, mqttpf_pkg::PROTOCOL_LEVEL,
                             mqttpf_pkg::PROTOCOL_NAME[7:0], mqttpf_pkg::PROTOCOL_NAME[15:8],
                             mqttpf_pkg::PROTOCOL_NAME[23:16], mqttpf_pkg::PROTOCOL_NAME[31:24],
                             8'h04, 8'h00};
                tail_cnt  = 4'd12;
            end
            mqttpf_pkg::KIND_SUBSCRIBE, mqttpf_pkg::KIND_UNSUBSCRIBE:
            begin
                type_byte = (packet_kind == mqttpf_pkg::KIND_SUBSCRIBE)
                          ? mqttpf_pkg::TYPE_SUBSCRIBE : mqttpf_pkg::TYPE_UNSUBSCRIBE;
                tail_vec  = {56'b0, 6'b0, qos_sat, first_length[7:0], first_length[15:8],
                             sub_ident_reg[7:0], sub_ident_reg[15:8]};
                tail_cnt  = (packet_kind == mqttpf_pkg::KIND_SUBSCRIBE
                             && first_length == 16'd0) ? 4'd5 : 4'd4;
            end
            mqttpf_pkg::KIND_PUBLISH:
            begin
                type_byte = mqttpf_pkg::TYPE_PUBLISH | {5'b0, qos_sat, 1'b0};
                tail_vec  = {64'b0, pub_ident_reg[7:0], pub_ident_reg[15:8],
                             first_length[7:0], first_length[15:8]};
                tail_cnt  = (first_length == 16'd0 && qos_sat != 2'd0) ? 4'd4 : 4'd2;
            end
            mqttpf_pkg::KIND_PINGREQ:
            begin
                type_byte = mqttpf_pkg::TYPE_PINGREQ;
            end
            default:
            begin
                type_byte = mqttpf_pkg::TYPE_DISCONNECT;
            end
        endcase
    end

    // payload side: current string and what ends with it
    always_comb
    begin
        seg     = 2'd0;
        seg_bad = 1'b0;
        pre     = 1'b0;
        unique case (phase_reg) inside
            mqttpf_pkg::PHASE_FIRST:
            begin
                seg = 2'd0;
            end
            mqttpf_pkg::PHASE_SECOND_PREFIX, mqttpf_pkg::PHASE_SECOND:
            begin
                seg = 2'd1;
                pre = (phase_reg == mqttpf_pkg::PHASE_SECOND_PREFIX);
            end
            mqttpf_pkg::PHASE_THIRD_PREFIX, mqttpf_pkg::PHASE_THIRD:
            begin
                seg = 2'd2;
                pre = (phase_reg == mqttpf_pkg::PHASE_THIRD_PREFIX);
            end
            default:
            begin
                seg_bad = 1'b1;
            end
        endcase

        unique case (seg)
            2'd0:    len_sel = len_reg[0];
            2'd1:    len_sel = len_reg[1];
            default: len_sel = len_reg[2];
        endcase

        nonzero = (len_sel != 16'd0);
        len_dec = len_sel - 16'd1;
        fire    = !nonzero || (len_dec == 16'd0);
        pre     = pre && nonzero;

        if (pre)
        begin
            head_vec = {payload_byte, len_sel[7:0], len_sel[15:8]};
            head_cnt = 2'd3;
        end
        else if (nonzero)
        begin
            head_vec = {16'b0, payload_byte};
            head_cnt = 2'd1;
        end
        else
        begin
            head_vec = '0;
            head_cnt = 2'd0;
        end

        done_vec   = '0;
        done_cnt   = 2'd0;
        done_close = 1'b1;
        done_phase = mqttpf_pkg::PHASE_FIRST;
        unique case (open_kind_reg)
            mqttpf_pkg::KIND_CONNECT:
            begin
                if (seg == 2'd0 && len_reg[1] != 16'd0)
                begin
                    done_close = 1'b0;
                    done_phase = mqttpf_pkg::PHASE_SECOND_PREFIX;
                end
                else if (seg != 2'd2 && len_reg[2] != 16'd0)
                begin
                    done_close = 1'b0;
                    done_phase = mqttpf_pkg::PHASE_THIRD_PREFIX;
                end
            end
            mqttpf_pkg::KIND_SUBSCRIBE:
            begin
                done_vec = {8'b0, 6'b0, held_qos_reg};
                done_cnt = 2'd1;
            end
            mqttpf_pkg::KIND_PUBLISH:
            begin
                if (seg == 2'd0)
                begin
                    if (held_qos_reg != 2'd0)
                    begin
                        done_vec = {pub_ident_reg[7:0], pub_ident_reg[15:8]};
                        done_cnt = 2'd2;
                    end
                    if (len_reg[1] != 16'd0)
                    begin
                        done_close = 1'b0;
                        done_phase = mqttpf_pkg::PHASE_SECOND;
                    end
                end
            end
            default:
            begin
                done_close = 1'b1;
            end
        endcase
    end

    // next state and burst contents
    always_comb
    begin
        open_kind_next = open_kind_reg;
        open_next      = open_reg;
        phase_next     = phase_reg;
        len_next       = len_reg;
        held_qos_next  = held_qos_reg;
        pub_ident_next = pub_ident_reg;
        burst_vec      = '0;
        burst_cnt      = '0;
        burst_close    = 1'b0;
        burst_drop     = 1'b0;

        if (mode)
        begin
            if (!open_reg)
            begin
                burst_cnt  = CW'(1);
                burst_drop = 1'b1;
            end
            else if (seg_bad)
            begin
                open_next  = 1'b0;
                phase_next = mqttpf_pkg::PHASE_FIRST;
            end
            else
            begin
                if (nonzero)
                begin
                    len_next[seg] = len_dec;
                end
                if (pre)
                begin
                    phase_next = (phase_reg == mqttpf_pkg::PHASE_SECOND_PREFIX)
                               ? mqttpf_pkg::PHASE_SECOND : mqttpf_pkg::PHASE_THIRD;
                end
                burst_vec = {{(BW-24){1'b0}}, head_vec};
                burst_cnt = CW'(head_cnt);
                if (fire)
                begin
                    burst_vec = burst_vec
                              | ({{(BW-16){1'b0}}, done_vec} << {head_cnt, 3'b000});
                    burst_cnt = CW'({1'b0, head_cnt} + {1'b0, done_cnt});
                    if (done_cnt == 2'd2)
                    begin
                        pub_ident_next = pub_ident_reg + 16'd1;
                    end
                    if (done_close)
                    begin
                        open_next   = 1'b0;
                        phase_next  = mqttpf_pkg::PHASE_FIRST;
                        burst_close = 1'b1;
                    end
                    else
                    begin
                        phase_next = done_phase;
                    end
                end
            end
        end
        else if (packet_kind <= mqttpf_pkg::KIND_DISCONNECT)
        begin
            open_kind_next = mqttpf_pkg::kind_t'(packet_kind);
            open_next      = 1'b1;
            phase_next     = mqttpf_pkg::PHASE_FIRST;
            held_qos_next  = qos_sat;
            len_next[0]    = '0;
            len_next[1]    = '0;
            len_next[2]    = '0;
            burst_vec = {{(BW-32){1'b0}}, vli_vec, type_byte}
                      | ({32'b0, tail_vec} << tail_shift);
            burst_cnt = CW'(5'd1 + {3'b000, vlen} + {1'b0, tail_cnt});
            unique case (packet_kind)
                mqttpf_pkg::KIND_CONNECT:
                begin
                    len_next[0] = first_length;
                    len_next[1] = second_length;
                    len_next[2] = third_length;
                    if (first_length == 16'd0)
                    begin
                        if (second_length != 16'd0)
                        begin
                            phase_next = mqttpf_pkg::PHASE_SECOND_PREFIX;
                        end
                        else if (third_length != 16'd0)
                        begin
                            phase_next = mqttpf_pkg::PHASE_THIRD_PREFIX;
                        end
                        else
                        begin
                            burst_close = 1'b1;
                        end
                    end
                end
                mqttpf_pkg::KIND_SUBSCRIBE, mqttpf_pkg::KIND_UNSUBSCRIBE:
                begin
                    len_next[0] = first_length;
                    burst_close = (first_length == 16'd0);
                end
                mqttpf_pkg::KIND_PUBLISH:
                begin
                    len_next[0] = first_length;
                    len_next[1] = second_length;
                    if (first_length == 16'd0)
                    begin
                        if (qos_sat != 2'd0)
                        begin
                            pub_ident_next = pub_ident_reg + 16'd1;
                        end
                        if (second_length != 16'd0)
                        begin
                            phase_next = mqttpf_pkg::PHASE_SECOND;
                        end
                        else
                        begin
                            burst_close = 1'b1;
                        end
                    end
                end
                default:
                begin
                    burst_close = 1'b1;
                end
            endcase
            if (burst_close)
            begin
                open_next  = 1'b0;
                phase_next = mqttpf_pkg::PHASE_FIRST;
            end
        end
    end

    // handshake
    assign out_load   = (buf_rem_reg != '0) && (!out_valid_reg || !result_stall);
    assign item_stall = !((buf_rem_reg == '0) || (buf_rem_reg == CW'(1) && out_load));
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_alive_reg <= mqttpf_pkg::KEEP_ALIVE_RESET;
            conn_flags_reg <= mqttpf_pkg::CONNECT_FLAGS_RESET;
            sub_ident_reg  <= mqttpf_pkg::SUBSCRIBE_IDENT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mqttpf_pkg::REG_KEEP_ALIVE:      keep_alive_reg <= cfg_data;
                mqttpf_pkg::REG_CONNECT_FLAGS:   conn_flags_reg <= cfg_data[7:0];
                mqttpf_pkg::REG_SUBSCRIBE_IDENT: sub_ident_reg  <= cfg_data;
                default:                         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_kind_reg <= mqttpf_pkg::KIND_CONNECT;
            open_reg      <= 1'b0;
            phase_reg     <= mqttpf_pkg::PHASE_FIRST;
            len_reg[0]    <= '0;
            len_reg[1]    <= '0;
            len_reg[2]    <= '0;
            held_qos_reg  <= '0;
            pub_ident_reg <= '0;
        end
        else if (accept)
        begin
            open_kind_reg <= open_kind_next;
            open_reg      <= open_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            held_qos_reg  <= held_qos_next;
            pub_ident_reg <= pub_ident_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_rem_reg   <= '0;
            buf_close_reg <= 1'b0;
            buf_drop_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                buf_rem_reg   <= burst_cnt;
                buf_close_reg <= burst_close;
                buf_drop_reg  <= burst_drop;
            end
            else if (out_load)
            begin
                buf_rem_reg <= buf_rem_reg - CW'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_data_reg <= burst_vec;
        end
        else if (out_load)
        begin
            buf_data_reg <= buf_data_reg >> 8;
        end

        if (out_load)
        begin
            out_byte_reg   <= buf_data_reg[7:0];
            out_last_reg   <= buf_close_reg && (buf_rem_reg == CW'(1));
            out_status_reg <= buf_drop_reg;
        end
    end

    assign result_valid   = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign last_of_packet = out_last_reg;
    assign status         = out_status_reg;

endmodule

`default_nettype wire

[rtl/core/mqttpf_checker.sv]
// Port-level assertions for the MQTT control packet framer, bound to the top level.
`default_nettype none

module mqttpf_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic        mode,
    input  logic [2:0]  packet_kind,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [7:0]  out_byte,
    input  logic        last_of_packet,
    input  logic        status,
    input  logic        cfg_valid,
    input  logic        cfg_ready
);

    // a held result word does not change
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(out_byte)
            && $stable(last_of_packet) && $stable(status))
        else $error("result word changed while stalled");

    // a dropped payload word is a lone zero byte, never a packet end
    a_drop_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |-> !last_of_packet && out_byte == 8'd0)
        else $error("drop flag on a packet byte");

    // a two-byte packet stalls the input in the cycle after it is taken
    a_short_burst: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !mode
            && (packet_kind == mqttpf_pkg::KIND_PINGREQ
                || packet_kind == mqttpf_pkg::KIND_DISCONNECT)
        |=> item_stall)
        else $error("input taken while header burst pending");

    // configuration is never back-pressured
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write blocked");

endmodule

bind mqtt_control_packet_framer_top mqttpf_checker u_mqttpf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .mode           (mode),
    .packet_kind    (packet_kind),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .out_byte       (out_byte),
    .last_of_packet (last_of_packet),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready)
);

`default_nettype wire
